@@ sv/u8cjk_pkg.sv @@
package u8cjk_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned LenW  = 3;
  localparam int unsigned PendW = 2;

  localparam logic [LenW-1:0] LenErr = 3'd0;
  localparam logic [LenW-1:0] Len1   = 3'd1;
  localparam logic [LenW-1:0] Len2   = 3'd2;
  localparam logic [LenW-1:0] Len3   = 3'd3;
  localparam logic [LenW-1:0] Len4   = 3'd4;

  localparam logic [PendW-1:0] PendNone = 2'd0;
  localparam logic [PendW-1:0] Pend1    = 2'd1;
  localparam logic [PendW-1:0] Pend2    = 2'd2;
  localparam logic [PendW-1:0] Pend3    = 2'd3;

  typedef struct packed {
    logic [CpW-1:0]  codepoint;
    logic [LenW-1:0] char_length;
    logic            is_cjk;
    logic            bad_lead;
  } u8cjk_result_t;

  typedef struct packed {
    logic          vld;
    u8cjk_result_t res;
  } u8cjk_dec_out_t;

endpackage

@@ sv/u8cjk_in_if.sv @@
interface u8cjk_in_if;
  import u8cjk_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

@@ sv/u8cjk_out_if.sv @@
interface u8cjk_out_if;
  import u8cjk_pkg::*;

  logic            valid;
  logic            ready;
  logic [CpW-1:0]  codepoint;
  logic [LenW-1:0] char_length;
  logic            is_cjk;
  logic            bad_lead;

  modport source (output valid, output codepoint, output char_length, output is_cjk,
                  output bad_lead, input ready);
  modport sink (input valid, input codepoint, input char_length, input is_cjk,
                input bad_lead, output ready);
endinterface

@@ sv/u8cjk_classify.sv @@
module u8cjk_classify
  import u8cjk_pkg::*;
(
  input  logic [CpW-1:0] cp,
  output logic           hit
);

  function automatic logic in_rng(logic [CpW-1:0] v, logic [CpW-1:0] lo,
                                  logic [CpW-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  always_comb begin
    hit = in_rng(cp, 21'h03000, 21'h0303F) ||
          in_rng(cp, 21'h03400, 21'h04DBF) ||
          in_rng(cp, 21'h04E00, 21'h09FFF) ||
          in_rng(cp, 21'h20000, 21'h2A6DF) ||
          in_rng(cp, 21'h2A700, 21'h2B739) ||
          in_rng(cp, 21'h2B740, 21'h2B81D) ||
          in_rng(cp, 21'h2B820, 21'h2CEA1) ||
          in_rng(cp, 21'h2CEB0, 21'h2EBE0) ||
          in_rng(cp, 21'h2EBF0, 21'h2EE5D) ||
          in_rng(cp, 21'h30000, 21'h3134A) ||
          in_rng(cp, 21'h31350, 21'h323AF) ||
          (cp == 21'h0FF01) || (cp == 21'h0FF0C) || (cp == 21'h0FF0E) ||
          (cp == 21'h0FF1A) || (cp == 21'h0FF1B) || (cp == 21'h0FF1F);
  end

endmodule

@@ sv/u8cjk_decode.sv @@
module u8cjk_decode
  import u8cjk_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [ByteW-1:0] b,
  output u8cjk_dec_out_t   dec
);

  logic [PendW-1:0] pend_r, pend_nxt;
  logic [LenW-1:0]  width_r, width_nxt;
  logic [CpW-1:0]   acc_r, acc_nxt;
  logic [CpW-1:0]   cp;
  logic [LenW-1:0]  len;
  logic             bad;
  logic             emit;
  logic             hit;

  always_comb begin
    pend_nxt  = pend_r;
    width_nxt = width_r;
    acc_nxt   = acc_r;
    cp        = '0;
    len       = LenErr;
    bad       = 1'b0;
    emit      = 1'b0;
    if (pend_r != PendNone) begin
      acc_nxt  = {acc_r[CpW-7:0], b[5:0]};
      pend_nxt = pend_r - Pend1;
      if (pend_nxt == PendNone) begin
        emit      = 1'b1;
        cp        = acc_nxt;
        len       = width_r;
        width_nxt = LenErr;
        acc_nxt   = '0;
      end
    end else if (b[7] == 1'b0) begin
      emit = 1'b1;
      cp   = {{(CpW-ByteW){1'b0}}, b};
      len  = Len1;
    end else if (b[7:5] == 3'b110) begin
      acc_nxt   = {{(CpW-5){1'b0}}, b[4:0]};
      width_nxt = Len2;
      pend_nxt  = Pend1;
    end else if (b[7:4] == 4'b1110) begin
      acc_nxt   = {{(CpW-4){1'b0}}, b[3:0]};
      width_nxt = Len3;
      pend_nxt  = Pend2;
    end else if (b[7:3] == 5'b11110) begin
      acc_nxt   = {{(CpW-3){1'b0}}, b[2:0]};
      width_nxt = Len4;
      pend_nxt  = Pend3;
    end else begin
      emit      = 1'b1;
      bad       = 1'b1;
      width_nxt = LenErr;
      acc_nxt   = '0;
    end
  end

  u8cjk_classify u_classify (
    .cp  (cp),
    .hit (hit)
  );

  always_comb begin
    dec.vld             = emit;
    dec.res.codepoint   = cp;
    dec.res.char_length = len;
    dec.res.is_cjk      = hit && !bad;
    dec.res.bad_lead    = bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= PendNone;
      width_r <= LenErr;
      acc_r   <= '0;
    end else if (advance) begin
      pend_r  <= pend_nxt;
      width_r <= width_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

@@ sv/utf8_decode_cjk_classify.sv @@
// UTF-8 decoder with CJK classification.
// in_ch carries one raw stream byte per transaction (valid/ready). out_ch
// carries one result per completed character or per invalid lead byte:
// codepoint, char_length, is_cjk and bad_lead. Continuation bytes and the
// lead byte of a multi-byte character produce no result until the last byte.
// A result is registered: the transaction of the byte that completes it loads
// the input register, and the decode step then loads the result register.
// Throughput: one byte per cycle while out_ch does not stall; the decode and
// classify step between the input and result registers is combinational.
// Reset (rst_n low, synchronous) empties both registers and returns the
// decoder to awaiting a lead byte; any partial character is dropped.
// When the receiver holds out_ch.ready low, the result register holds, the
// input register holds one more byte, and in_ch.ready then drops until the
// result is taken.
module utf8_decode_cjk_classify
  import u8cjk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  u8cjk_in_if.sink   in_ch,
  u8cjk_out_if.source out_ch
);

  logic             in_vld_r;
  logic [ByteW-1:0] in_byte_r;
  logic             out_vld_r;
  u8cjk_result_t    out_res_r;
  logic             advance;
  u8cjk_dec_out_t   dec;

  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  u8cjk_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .b       (in_byte_r),
    .dec     (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (advance) begin
        out_vld_r <= dec.vld;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.byte_in;
    end
    if (advance && dec.vld) begin
      out_res_r <= dec.res;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.codepoint   = out_res_r.codepoint;
  assign out_ch.char_length = out_res_r.char_length;
  assign out_ch.is_cjk      = out_res_r.is_cjk;
  assign out_ch.bad_lead    = out_res_r.bad_lead;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import u8cjk_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned ItemsPerPhase = 400;

  class utf8_char_tracker;
    logic [PendW-1:0] pend;
    logic [LenW-1:0]  width;
    logic [CpW-1:0]   acc;
    u8cjk_result_t    expected_chars[$];
    int unsigned      failures;
    int unsigned      chars_seen;
    int unsigned      cjk_seen;
    int unsigned      bad_seen;

    function new();
      pend = PendNone;
      width = LenErr;
      acc = '0;
      failures = 0;
      chars_seen = 0;
      cjk_seen = 0;
      bad_seen = 0;
    endfunction

    function logic in_cjk_set(logic [CpW-1:0] c);
      return (c >= 21'h03000 && c <= 21'h0303F) ||
             (c >= 21'h03400 && c <= 21'h04DBF) ||
             (c >= 21'h04E00 && c <= 21'h09FFF) ||
             (c >= 21'h20000 && c <= 21'h2A6DF) ||
             (c >= 21'h2A700 && c <= 21'h2B739) ||
             (c >= 21'h2B740 && c <= 21'h2B81D) ||
             (c >= 21'h2B820 && c <= 21'h2CEA1) ||
             (c >= 21'h2CEB0 && c <= 21'h2EBE0) ||
             (c >= 21'h2EBF0 && c <= 21'h2EE5D) ||
             (c >= 21'h30000 && c <= 21'h3134A) ||
             (c >= 21'h31350 && c <= 21'h323AF) ||
             c == 21'h0FF01 || c == 21'h0FF0C || c == 21'h0FF0E ||
             c == 21'h0FF1A || c == 21'h0FF1B || c == 21'h0FF1F;
    endfunction

    function void push_char(logic [CpW-1:0] c, logic [LenW-1:0] len, logic bad);
      u8cjk_result_t r;
      r.codepoint = c;
      r.char_length = len;
      r.is_cjk = bad ? 1'b0 : in_cjk_set(c);
      r.bad_lead = bad;
      expected_chars.push_back(r);
    endfunction

    function void decode_byte(logic [ByteW-1:0] b);
      if (pend != PendNone) begin
        acc = {acc[CpW-7:0], b[5:0]};
        pend = pend - 1'b1;
        if (pend == PendNone) begin
          push_char(acc, width, 1'b0);
          width = LenErr;
          acc = '0;
        end
      end else if (!b[7]) begin
        push_char({13'd0, b}, Len1, 1'b0);
      end else if (b[7:5] == 3'b110) begin
        acc = {16'd0, b[4:0]};
        width = Len2;
        pend = Pend1;
      end else if (b[7:4] == 4'b1110) begin
        acc = {17'd0, b[3:0]};
        width = Len3;
        pend = Pend2;
      end else if (b[7:3] == 5'b11110) begin
        acc = {18'd0, b[2:0]};
        width = Len4;
        pend = Pend3;
      end else begin
        push_char('0, LenErr, 1'b1);
        width = LenErr;
        acc = '0;
      end
    endfunction

    function void compare_char(u8cjk_result_t got);
      u8cjk_result_t exp_r;
      if (expected_chars.size() == 0) begin
        $error("unexpected result: codepoint %h length %0d cjk %b bad %b",
               got.codepoint, got.char_length, got.is_cjk, got.bad_lead);
        failures++;
        return;
      end
      exp_r = expected_chars.pop_front();
      chars_seen++;
      if (got.is_cjk) cjk_seen++;
      if (got.bad_lead) bad_seen++;
      if (got.codepoint !== exp_r.codepoint) begin
        $error("codepoint: expected %h, actual %h", exp_r.codepoint, got.codepoint);
        failures++;
      end
      if (got.char_length !== exp_r.char_length) begin
        $error("char_length: expected %0d, actual %0d", exp_r.char_length, got.char_length);
        failures++;
      end
      if (got.is_cjk !== exp_r.is_cjk) begin
        $error("is_cjk: expected %b, actual %b", exp_r.is_cjk, got.is_cjk);
        failures++;
      end
      if (got.bad_lead !== exp_r.bad_lead) begin
        $error("bad_lead: expected %b, actual %b", exp_r.bad_lead, got.bad_lead);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  u8cjk_in_if  in_ch();
  u8cjk_out_if out_ch();

  utf8_decode_cjk_classify dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  utf8_char_tracker tracker;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned bytes_sent;
  int unsigned cycle_count = 0;
  bit          hold_req;

  int unsigned cjk_edges [28] = '{
    21'h03000, 21'h0303F, 21'h03400, 21'h04DBF, 21'h04E00, 21'h09FFF,
    21'h20000, 21'h2A6DF, 21'h2A700, 21'h2B739, 21'h2B740, 21'h2B81D,
    21'h2B820, 21'h2CEA1, 21'h2CEB0, 21'h2EBE0, 21'h2EBF0, 21'h2EE5D,
    21'h30000, 21'h3134A, 21'h31350, 21'h323AF, 21'h0FF01, 21'h0FF0C,
    21'h0FF0E, 21'h0FF1A, 21'h0FF1B, 21'h0FF1F
  };

  logic [7:0] directed_bytes [23] = '{
    8'h00, 8'h7F, 8'h80, 8'hFF, 8'hF8,
    8'hC0, 8'h80,
    8'hDF, 8'hBF,
    8'hE3, 8'h80, 8'h80,
    8'hEF, 8'hBC, 8'h9F,
    8'hF0, 8'hA0, 8'h80, 8'h80,
    8'hF7, 8'hBF, 8'hFF, 8'h7F
  };

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.byte_in <= b;
    do @(posedge clk); while (!in_ch.ready);
    tracker.decode_byte(b);
    bytes_sent++;
  endtask

  function automatic logic [7:0] cont_byte(logic [5:0] p, bit junk);
    logic [1:0] top;
    top = junk ? 2'($urandom_range(3)) : 2'b10;
    return {top, p};
  endfunction

  task automatic send_random_char();
    logic [CpW-1:0] cp;
    int v;
    int len;
    bit junk;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        v = int'(cjk_edges[$urandom_range(27)]) + int'($urandom_range(4)) - 2;
        cp = CpW'(v);
      end
      4:       cp = CpW'($urandom_range(8'h7F));
      5:       cp = CpW'($urandom_range(12'h7FF));
      6, 7:    cp = CpW'($urandom_range(16'hFFFF));
      8:       cp = CpW'($urandom_range(21'h1FFFFF));
      default: cp = CpW'($urandom_range(21'h10FFFF));
    endcase
    if (cp < 21'h80) len = 1;
    else if (cp < 21'h800) len = 2;
    else if (cp < 21'h10000) len = 3;
    else len = 4;
    if (len < 4 && $urandom_range(19) == 0) len++;
    junk = ($urandom_range(9) == 0);
    case (len)
      1: send_byte({1'b0, cp[6:0]});
      2: begin
        send_byte({3'b110, cp[10:6]});
        send_byte(cont_byte(cp[5:0], junk));
      end
      3: begin
        send_byte({4'b1110, cp[15:12]});
        send_byte(cont_byte(cp[11:6], junk));
        send_byte(cont_byte(cp[5:0], junk));
      end
      default: begin
        send_byte({5'b11110, cp[20:18]});
        send_byte(cont_byte(cp[17:12], junk));
        send_byte(cont_byte(cp[11:6], junk));
        send_byte(cont_byte(cp[5:0], junk));
      end
    endcase
  endtask

  task automatic run_random(input int unsigned n_bytes);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(99) < 10) send_byte(8'($urandom_range(255)));
      else send_random_char();
    end
  endtask

  task automatic receive_results();
    u8cjk_result_t got;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
        @(posedge clk);
        if (out_ch.valid && out_ch.ready) begin
          got.codepoint = out_ch.codepoint;
          got.char_length = out_ch.char_length;
          got.is_cjk = out_ch.is_cjk;
          got.bad_lead = out_ch.bad_lead;
          tracker.compare_char(got);
        end
      end
    end
  endtask

  initial begin
    tracker = new();
    bytes_sent = 0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.byte_in = '0;
    out_ch.ready = 1'b0;
    in_idle_pct = 38;
    out_idle_pct = 80;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    fork
      receive_results();
    join_none

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    run_random(ItemsPerPhase);

    in_idle_pct = 80;
    out_idle_pct = 38;
    run_random(ItemsPerPhase);

    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_req = 1'b1;
    run_random(ItemsPerPhase);

    in_ch.valid <= 1'b0;
    while (tracker.expected_chars.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes over three flow-control phases with one long output stall.",
             bytes_sent);
    $display("Checked %0d results: %0d CJK, %0d invalid lead bytes.",
             tracker.chars_seen, tracker.cjk_seen, tracker.bad_seen);
    if (tracker.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
